FILE: rtl/core/lcdseq_pkg.sv
// Shared types, codes and phase tables for the character LCD nibble sequencer.
package lcdseq_pkg;

  localparam int QueueDepth = 2;

  localparam logic [3:0] HoldEnHigh = 4'd7;
  localparam logic [3:0] HoldEnLow  = 4'd13;
  localparam logic [4:0] InitLastStep = 5'd24;
  localparam logic [4:0] ByteLastStep = 5'd3;
  localparam logic [4:0] InitPreSteps = 5'd5;

  typedef enum logic [3:0] {
    OP_INIT         = 4'd0,
    OP_CHAR         = 4'd1,
    OP_ADDRESS      = 4'd2,
    OP_CLEAR        = 4'd3,
    OP_HOME         = 4'd4,
    OP_ENTRY_MODE   = 4'd5,
    OP_DISPLAY_CTRL = 4'd6,
    OP_SHIFT_DISP   = 4'd7,
    OP_SHIFT_CURSOR = 4'd8
  } op_t;

  // One queued request: either the init script or a single byte.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
    logic [8:0] slow;
  } req_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nibble;
    logic [3:0] hold_fast;
    logic [8:0] hold_slow;
    logic       last;
  } phase_t;

  function automatic phase_t byte_phase(logic rs, logic [7:0] b, logic [1:0] sub,
                                        logic [8:0] slow, logic last);
    phase_t p;
    p.rs        = rs;
    p.hold_slow = 9'd0;
    p.last      = 1'b0;
    case (sub)
      2'd0: begin
        p.en = 1'b1; p.nibble = b[7:4]; p.hold_fast = HoldEnHigh;
      end
      2'd1: begin
        p.en = 1'b0; p.nibble = b[7:4]; p.hold_fast = HoldEnLow;
      end
      2'd2: begin
        p.en = 1'b1; p.nibble = b[3:0]; p.hold_fast = HoldEnHigh;
      end
      default: begin
        p.en = 1'b0; p.nibble = b[3:0]; p.hold_fast = 4'd0;
        p.hold_slow = slow; p.last = last;
      end
    endcase
    return p;
  endfunction

  function automatic phase_t init_phase(logic [4:0] step);
    phase_t     p;
    logic [4:0] idx;
    logic [7:0] b;
    logic [8:0] slow;
    idx = step - InitPreSteps;
    p = '0;
    case (idx[4:2])
      3'd0:    begin b = 8'h32; slow = 9'd2;  end
      3'd1:    begin b = 8'h28; slow = 9'd2;  end
      3'd2:    begin b = 8'h01; slow = 9'd30; end
      3'd3:    begin b = 8'h06; slow = 9'd2;  end
      default: begin b = 8'h0F; slow = 9'd2;  end
    endcase
    case (step)
      5'd0: p.hold_slow = 9'd300;
      5'd1, 5'd3: begin
        p.en = 1'b1; p.nibble = 4'h3; p.hold_fast = HoldEnHigh;
      end
      5'd2: begin p.nibble = 4'h3; p.hold_slow = 9'd90;  end
      5'd4: begin p.nibble = 4'h3; p.hold_slow = 9'd100; end
      default: p = byte_phase(1'b0, b, idx[1:0], slow, step == InitLastStep);
    endcase
    return p;
  endfunction

  function automatic phase_t phase_of(req_t r, logic [4:0] step);
    phase_t p;
    if (r.is_init) p = init_phase(step);
    else p = byte_phase(r.rs, r.byte_val, step[1:0], r.slow, 1'b1);
    return p;
  endfunction

endpackage

FILE: rtl/core/lcdseq_front.sv
// Front end: accepts requests and encodes each known opcode into a queued byte or init request.
module lcdseq_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           opcode,
  input  logic [7:0]           char_code,
  input  logic [7:0]           line,
  input  logic [7:0]           position,
  input  logic [1:0]           entry_mode_sel,
  input  logic [1:0]           display_sel,
  input  logic                 direction,
  input  logic                 wait_flag,
  input  logic                 q_full,
  output logic                 push,
  output lcdseq_pkg::req_t     push_req
);
  import lcdseq_pkg::*;

  logic [5:0] pos_clamped;
  logic       known;
  logic [8:0] clr_slow;

  assign in_ready    = !q_full;
  assign pos_clamped = (position > 8'd39) ? 6'd39 : position[5:0];
  assign clr_slow    = wait_flag ? 9'd30 : 9'd0;

  always_comb begin
    push_req = '{is_init: 1'b0, rs: 1'b0, byte_val: 8'h00, slow: 9'd1};
    known    = 1'b1;
    case (opcode)
      OP_INIT:       push_req.is_init = 1'b1;
      OP_CHAR: begin
        push_req.rs = 1'b1; push_req.byte_val = char_code;
      end
      OP_ADDRESS:    push_req.byte_val = {1'b1, line != 8'd0, pos_clamped};
      OP_CLEAR: begin
        push_req.byte_val = 8'h01; push_req.slow = clr_slow;
      end
      OP_HOME: begin
        push_req.byte_val = 8'h02; push_req.slow = clr_slow;
      end
      OP_ENTRY_MODE: begin
        case (entry_mode_sel)
          2'd0:    push_req.byte_val = 8'h06;
          2'd1:    push_req.byte_val = 8'h04;
          2'd2:    push_req.byte_val = 8'h07;
          default: push_req.byte_val = 8'h05;
        endcase
      end
      OP_DISPLAY_CTRL: begin
        case (display_sel)
          2'd0:    push_req.byte_val = 8'h08;
          2'd1:    push_req.byte_val = 8'h0C;
          2'd2:    push_req.byte_val = 8'h0E;
          default: push_req.byte_val = 8'h0F;
        endcase
      end
      OP_SHIFT_DISP:   push_req.byte_val = direction ? 8'h1C : 8'h18;
      OP_SHIFT_CURSOR: push_req.byte_val = direction ? 8'h14 : 8'h10;
      default:         known = 1'b0;
    endcase
  end

  assign push = in_valid && !q_full && known;

endmodule

FILE: rtl/core/lcdseq_queue.sv
// Small request queue between the front and back ends.
module lcdseq_queue #(
  parameter int DEPTH = lcdseq_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lcdseq_pkg::req_t push_req,
  output logic             full,
  output logic             q_valid,
  output lcdseq_pkg::req_t q_req,
  input  logic             pop
);
  import lcdseq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrMax = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CntMax = CW'(DEPTH);

  req_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CntMax;
  assign q_valid = count != '0;
  assign q_req   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrMax) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrMax) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/core/lcdseq_back.sv
// Back end: steps through the pin phases of one request into the output register.
module lcdseq_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  lcdseq_pkg::req_t q_req,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             rs_pin,
  output logic             en_pin,
  output logic [3:0]       nibble,
  output logic [3:0]       hold_fast,
  output logic [8:0]       hold_slow,
  output logic             last
);
  import lcdseq_pkg::*;

  logic       busy;
  logic [4:0] step;
  req_t       cur;
  phase_t     ph;
  logic       adv;
  logic       at_final;

  assign adv      = !out_valid || out_ready;
  assign at_final = cur.is_init ? (step == InitLastStep) : (step == ByteLastStep);
  assign pop      = q_valid && (!busy || (adv && at_final));
  assign ph       = phase_of(cur, step);

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      rs_pin    <= ph.rs;
      en_pin    <= ph.en;
      nibble    <= ph.nibble;
      hold_fast <= ph.hold_fast;
      hold_slow <= ph.hold_slow;
      last      <= ph.last;
    end
    if (pop) cur <= q_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (busy && adv) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy && adv) begin
        if (at_final) busy <= 1'b0;
        else step <= step + 1'b1;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= (cur.is_init ? InitLastStep : ByteLastStep)))
    else $error("phase step beyond end of request");

  a_final_sets_last: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && at_final) |=> (out_valid && last))
    else $error("final phase not marked last");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && !at_final) |=> (out_valid && !last))
    else $error("non-final phase marked last");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

FILE: rtl/core/char_lcd_nibble_command_sequencer.sv
// Top level of the 4-bit character LCD command sequencer.
//   channel | handshake           | payload
//   in      | in_valid/in_ready   | opcode, char_code, line, position, entry_mode_sel,
//           |                     | display_sel, direction, wait_flag
//   out     | out_valid/out_ready | rs_pin, en_pin, nibble, hold_fast, hold_slow, last
// One pin phase per cycle unless out_ready stalls: 4 per byte request, 25 for init.
// Front accepts one item per cycle while the request queue has room; unknown opcodes
// are accepted and dropped. Back loads the next request as it emits the final phase.
// Synchronous reset clears queue, step state and out_valid; out_ready low stalls the
// back end only.
module char_lcd_nibble_command_sequencer #(
  parameter int QDEPTH = lcdseq_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] opcode,
  input  logic [7:0] char_code,
  input  logic [7:0] line,
  input  logic [7:0] position,
  input  logic [1:0] entry_mode_sel,
  input  logic [1:0] display_sel,
  input  logic       direction,
  input  logic       wait_flag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       rs_pin,
  output logic       en_pin,
  output logic [3:0] nibble,
  output logic [3:0] hold_fast,
  output logic [8:0] hold_slow,
  output logic       last
);
  import lcdseq_pkg::*;

  logic push;
  req_t push_req;
  logic q_full;
  logic q_valid;
  req_t q_req;
  logic pop;

  lcdseq_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .char_code      (char_code),
    .line           (line),
    .position       (position),
    .entry_mode_sel (entry_mode_sel),
    .display_sel    (display_sel),
    .direction      (direction),
    .wait_flag      (wait_flag),
    .q_full         (q_full),
    .push           (push),
    .push_req       (push_req)
  );

  lcdseq_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .pop      (pop)
  );

  lcdseq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rs_pin    (rs_pin),
    .en_pin    (en_pin),
    .nibble    (nibble),
    .hold_fast (hold_fast),
    .hold_slow (hold_slow),
    .last      (last)
  );

endmodule
